// ----- design/tc_pkg.sv -----
// Shared types, constants and helpers of the triangle rectangle clipper.
package tc_pkg;

  localparam int COORD_W   = 32;
  localparam int DIV_STEPS = COORD_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int QDEPTH    = 2;
  localparam int CFG_IDX_W = 3;

  // Inside mask codes, one bit per vertex
  localparam logic [2:0] MASK_NONE = 3'b000;
  localparam logic [2:0] MASK_A    = 3'b001;
  localparam logic [2:0] MASK_B    = 3'b010;
  localparam logic [2:0] MASK_C    = 3'b100;
  localparam logic [2:0] MASK_ALL  = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_RIGHT  = 3'd2,
    CFG_BOTTOM = 3'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    K_PASS,
    K_ONE,
    K_TWO
  } job_kind_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_SEED,
    L_DIV
  } lerp_st_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CALC,
    B_WAIT,
    B_EMIT0,
    B_EMIT1
  } back_st_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_a_x;
    logic signed [COORD_W-1:0] out_a_y;
    logic signed [COORD_W-1:0] out_a_z;
    logic signed [COORD_W-1:0] out_b_x;
    logic signed [COORD_W-1:0] out_b_y;
    logic signed [COORD_W-1:0] out_b_z;
    logic signed [COORD_W-1:0] out_c_x;
    logic signed [COORD_W-1:0] out_c_y;
    logic signed [COORD_W-1:0] out_c_z;
    logic                      last_of_run;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } bounds_t;

  typedef struct packed {
    job_kind_e    kind;
    logic [1:0]   k;
    vtx_t [2:0]   v;
  } job_t;

  function automatic logic inside_f(vtx_t p, bounds_t b);
    return ($signed(p.x) >= $signed(b.left)) && ($signed(p.x) <= $signed(b.right)) &&
           ($signed(p.y) >= $signed(b.top)) && ($signed(p.y) <= $signed(b.bottom));
  endfunction

  // Magnitude of a sign-extended difference
  function automatic logic [COORD_W:0] mag_f(logic signed [COORD_W:0] v);
    return v[COORD_W] ? (~v + 1'b1) : v;
  endfunction

  // Cyclic successor of a vertex slot
  function automatic logic [1:0] nxt_f(logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/tc_lerp.sv -----
// Iterative interpolator: wc + sign(lc-wc) * floor(|lc-wc| * n / d).
module tc_lerp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [tc_pkg::COORD_W-1:0]  wc_i,
  input  logic signed [tc_pkg::COORD_W-1:0]  lc_i,
  input  logic [tc_pkg::COORD_W:0]           n_i,
  input  logic [tc_pkg::COORD_W:0]           d_i,
  output logic                               done_o,
  output logic signed [tc_pkg::COORD_W-1:0]  res_o
);
  import tc_pkg::*;

  localparam int W = COORD_W;

  lerp_st_e           state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;

  logic signed [W-1:0] wc_q;
  logic                neg_q;
  logic [W:0]          m_q, n_q, d_q;
  logic [2*W+1:0]      prod_q;
  logic [W+1:0]        r_q;
  logic [W:0]          sh_q, q_q;

  logic signed [W:0]   diff;
  logic [W+1:0]        r_try;
  logic                ge;
  logic signed [W+1:0] sum;

  // Difference and one restoring step
  assign diff  = $signed({lc_i[W-1], lc_i}) - $signed({wc_i[W-1], wc_i});
  assign r_try = {r_q[W:0], sh_q[W]};
  assign ge    = r_try >= {1'b0, d_q};

  // Next state and sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    case (state_q)
      L_IDLE: begin
        if (start_i) state_d = L_MUL;
      end
      L_MUL: begin
        state_d = L_SEED;
      end
      L_SEED: begin
        state_d = L_DIV;
        cnt_d   = CNT_W'(DIV_STEPS);
      end
      L_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath: latch, multiply, seed remainder, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          wc_q  <= wc_i;
          neg_q <= diff[W];
          m_q   <= mag_f(diff);
          n_q   <= n_i;
          d_q   <= d_i;
        end
      end
      L_MUL: begin
        prod_q <= m_q * n_q;
      end
      L_SEED: begin
        r_q  <= {1'b0, prod_q[2*W+1:W+1]};
        sh_q <= prod_q[W:0];
        q_q  <= '0;
      end
      L_DIV: begin
        r_q  <= ge ? (r_try - {1'b0, d_q}) : r_try;
        sh_q <= {sh_q[W-1:0], 1'b0};
        q_q  <= {q_q[W-1:0], ge};
      end
      default: ;
    endcase
  end

  assign sum    = neg_q ? ($signed({wc_q[W-1], wc_q[W-1], wc_q}) - $signed({1'b0, q_q}))
                        : ($signed({wc_q[W-1], wc_q[W-1], wc_q}) + $signed({1'b0, q_q}));
  assign res_o  = sum[W-1:0];
  assign done_o = done_q;

endmodule

// ----- design/tc_fifo.sv -----
// Short job queue between the classifier and the clipping engine.
module tc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tc_pkg::job_t  job_i,
  input  logic          pop_i,
  output tc_pkg::job_t  job_o,
  output logic          full_o,
  output logic          empty_o
);
  import tc_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          mem_q [QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ----- design/tc_front.sv -----
// Front end: accept a triangle, classify its vertices, queue the job unless it is fully outside.
module tc_front (
  input  logic             start_i,
  input  tc_pkg::in_t      in_i,
  input  tc_pkg::bounds_t  bounds_i,
  input  logic             full_i,
  output logic             push_o,
  output tc_pkg::job_t     job_o
);
  import tc_pkg::*;

  logic [2:0] mask;
  logic       keep;

  always_comb begin
    job_o.v[0] = '{x: in_i.a_x, y: in_i.a_y, z: in_i.a_z};
    job_o.v[1] = '{x: in_i.b_x, y: in_i.b_y, z: in_i.b_z};
    job_o.v[2] = '{x: in_i.c_x, y: in_i.c_y, z: in_i.c_z};
    mask = {inside_f(job_o.v[2], bounds_i), inside_f(job_o.v[1], bounds_i),
            inside_f(job_o.v[0], bounds_i)};
    keep       = 1'b1;
    job_o.kind = K_TWO;
    job_o.k    = 2'd0;
    // Pick the kind and the pivot slot; drop triangles fully outside
    case (mask)
      MASK_ALL:  job_o.kind = K_PASS;
      MASK_NONE: keep = 1'b0;
      MASK_A: begin
        job_o.kind = K_ONE;
        job_o.k    = 2'd0;
      end
      MASK_B: begin
        job_o.kind = K_ONE;
        job_o.k    = 2'd1;
      end
      MASK_C: begin
        job_o.kind = K_ONE;
        job_o.k    = 2'd2;
      end
      default: begin
        job_o.kind = K_TWO;
        job_o.k    = !mask[0] ? 2'd0 : (!mask[1] ? 2'd1 : 2'd2);
      end
    endcase
  end

  assign push_o = start_i && !full_i && keep;

endmodule

// ----- design/tc_back.sv -----
// Back end: form edge crossings and emit the clipped triangles.
module tc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tc_pkg::bounds_t  bounds_i,
  input  logic             empty_i,
  input  tc_pkg::job_t     job_i,
  output logic             pop_o,
  output logic             strobe_o,
  output tc_pkg::out_t     res_o
);
  import tc_pkg::*;

  localparam int W = COORD_W;

  back_st_e   state_q, state_d;
  job_t       job_q;
  out_t       res_q, res_d;
  logic       strobe_q, strobe_d;
  logic       lerp_start;
  logic [7:0] lerp_done;

  logic [1:0] i1, i2;
  vtx_t       w [2];
  vtx_t       l [2];
  vtx_t       cr [2];
  vtx_t [2:0] t;

  function automatic out_t pack_f(vtx_t a, vtx_t b, vtx_t c, logic last);
    out_t o;
    o = '{a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z, last};
    return o;
  endfunction

  // Select the outside/inside vertex pair of each crossing
  always_comb begin
    i1 = nxt_f(job_q.k);
    i2 = nxt_f(i1);
    if (job_q.kind == K_TWO) begin
      w[0] = job_q.v[job_q.k];
      l[0] = job_q.v[i1];
      w[1] = job_q.v[job_q.k];
      l[1] = job_q.v[i2];
    end else begin
      w[0] = job_q.v[i1];
      l[0] = job_q.v[job_q.k];
      w[1] = job_q.v[i2];
      l[1] = job_q.v[job_q.k];
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_cross
    logic             xl, xr, yt, yb, hx, hy;
    logic signed [W-1:0] bx, by;
    logic [W:0]       nx, dx, ny, dy;
    logic signed [W-1:0] r [4];
    vtx_t             cx, cy;

    assign xl = $signed(w[j].x) < $signed(bounds_i.left);
    assign xr = $signed(w[j].x) > $signed(bounds_i.right);
    assign yt = $signed(w[j].y) < $signed(bounds_i.top);
    assign yb = $signed(w[j].y) > $signed(bounds_i.bottom);
    assign hx = xl || xr;
    assign hy = yt || yb;
    assign bx = xl ? bounds_i.left : bounds_i.right;
    assign by = yt ? bounds_i.top : bounds_i.bottom;
    assign nx = mag_f($signed({bx[W-1], bx}) - $signed({w[j].x[W-1], w[j].x}));
    assign dx = mag_f($signed({l[j].x[W-1], l[j].x}) - $signed({w[j].x[W-1], w[j].x}));
    assign ny = mag_f($signed({by[W-1], by}) - $signed({w[j].y[W-1], w[j].y}));
    assign dy = mag_f($signed({l[j].y[W-1], l[j].y}) - $signed({w[j].y[W-1], w[j].y}));

    // x-bound candidate: y and z; y-bound candidate: x and z
    tc_lerp u_ly (.clk_i, .rst_ni, .start_i(lerp_start), .wc_i(w[j].y), .lc_i(l[j].y),
                  .n_i(nx), .d_i(dx), .done_o(lerp_done[4*j]), .res_o(r[0]));
    tc_lerp u_lzx (.clk_i, .rst_ni, .start_i(lerp_start), .wc_i(w[j].z), .lc_i(l[j].z),
                   .n_i(nx), .d_i(dx), .done_o(lerp_done[4*j+1]), .res_o(r[1]));
    tc_lerp u_lx (.clk_i, .rst_ni, .start_i(lerp_start), .wc_i(w[j].x), .lc_i(l[j].x),
                  .n_i(ny), .d_i(dy), .done_o(lerp_done[4*j+2]), .res_o(r[2]));
    tc_lerp u_lzy (.clk_i, .rst_ni, .start_i(lerp_start), .wc_i(w[j].z), .lc_i(l[j].z),
                   .n_i(ny), .d_i(dy), .done_o(lerp_done[4*j+3]), .res_o(r[3]));

    assign cx = '{x: bx, y: r[0], z: r[1]};
    assign cy = '{x: r[2], y: by, z: r[3]};

    // Past a corner prefer the x candidate unless only the y one is inside
    always_comb begin
      if (hx && hy) begin
        cr[j] = (!inside_f(cx, bounds_i) && inside_f(cy, bounds_i)) ? cy : cx;
      end else if (hx) begin
        cr[j] = cx;
      end else if (hy) begin
        cr[j] = cy;
      end else begin
        cr[j] = w[j];
      end
    end
  end

  // One inside: replace each outside slot by its crossing
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      if (2'(s) == job_q.k)   t[s] = job_q.v[s];
      else if (2'(s) == i1)   t[s] = cr[0];
      else                    t[s] = cr[1];
    end
  end

  // Sequence pop, crossing, and emission
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    lerp_start = 1'b0;
    strobe_d   = 1'b0;
    res_d      = res_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = (job_i.kind == K_PASS) ? B_EMIT0 : B_CALC;
        end
      end
      B_CALC: begin
        lerp_start = 1'b1;
        state_d    = B_WAIT;
      end
      B_WAIT: begin
        if (&lerp_done) state_d = B_EMIT0;
      end
      B_EMIT0: begin
        strobe_d = 1'b1;
        case (job_q.kind)
          K_PASS:  res_d = pack_f(job_q.v[0], job_q.v[1], job_q.v[2], 1'b1);
          K_ONE:   res_d = pack_f(t[0], t[1], t[2], 1'b1);
          default: res_d = pack_f(cr[1], cr[0], job_q.v[i1], 1'b0);
        endcase
        state_d = (job_q.kind == K_TWO) ? B_EMIT1 : B_IDLE;
      end
      B_EMIT1: begin
        strobe_d = 1'b1;
        res_d    = pack_f(cr[1], job_q.v[i1], job_q.v[i2], 1'b1);
        state_d  = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

`ifndef SYNTHESIS
  a_done_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|lerp_done) |-> (&lerp_done)) else $error("interpolators finished out of step");
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !res_q.last_of_run) |=> (strobe_q && res_q.last_of_run))
    else $error("second triangle of a pair missing");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WAIT) |-> !pop_o) else $error("job popped while crossings run");
`endif

endmodule

// ----- design/triangle_rect_clipper.sv -----
// Top level of the triangle clipper against an axis-aligned rectangle.
// A fully inside triangle is passed on as it is; a clipped one waits for the
// 33-step iterative dividers in the interpolators, and a 2-deep queue keeps accepting
// new triangles meanwhile.
// Reset: bounds clear to 0, queue empties, no result pending. Results cannot be stalled.
module triangle_rect_clipper (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  tc_pkg::in_t                            in_i,
  output logic                                   strobe_o,
  output tc_pkg::out_t                           res_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tc_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic signed [tc_pkg::COORD_W-1:0]      cfg_data_i
);
  import tc_pkg::*;

  bounds_t bounds_q;
  logic    push, pop, full, empty;
  job_t    job_in, job_head;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  // Hold the clip rectangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        CFG_LEFT:   bounds_q.left   <= cfg_data_i;
        CFG_TOP:    bounds_q.top    <= cfg_data_i;
        CFG_RIGHT:  bounds_q.right  <= cfg_data_i;
        CFG_BOTTOM: bounds_q.bottom <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tc_front u_front (
    .start_i  (start),
    .in_i     (in_i),
    .bounds_i (bounds_q),
    .full_i   (full),
    .push_o   (push),
    .job_o    (job_in)
  );

  tc_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_head),
    .full_o  (full),
    .empty_o (empty)
  );

  tc_back u_back (
    .clk_i,
    .rst_ni,
    .bounds_i (bounds_q),
    .empty_i  (empty),
    .job_i    (job_head),
    .pop_o    (pop),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

endmodule
